// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hpoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hpoa_pkg;
  localparam logic [15:0] HExpMask    = 16'h7C00;
  localparam logic [15:0] HQuiet      = 16'h0200;
  localparam logic [15:0] HDefaultNan = 16'h7E00;
  localparam logic [15:0] HSign       = 16'h8000;
  localparam int          MagW        = 42;

  typedef struct packed {
    logic [15:0] local_value;
    logic [15:0] peer_value;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] sum_value;
    logic        last_out;
  } out_beat_t;
endpackage
`default_nettype wire

// ===== rtl/hpoa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hpoa_in_if;
  logic              valid;
  logic              ready;
  hpoa_pkg::in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/hpoa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hpoa_out_if;
  logic               valid;
  logic               ready;
  hpoa_pkg::out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/half_precision_ordered_add.sv =====
// Five register stages lie between input beat and result beat.
// Throughput: one beat per cycle; every stage holds when the output stalls.
// Stages: decode/align, add, round to 24 bits, round to 11 bits, pack into output.
// Reset: rst_n is synchronous, active low; clears valid bits and rank_r.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module half_precision_ordered_add (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  hpoa_in_if.sink    in_ch,
  hpoa_out_if.source out_ch
);
  localparam int W = hpoa_pkg::MagW;

  logic rank_r;
  logic [4:0] v_r;
  logic adv;

  // whole pipe advances unless the output holds a beat that is not taken
  assign adv = !v_r[4] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) rank_r <= 1'b0;
    else if (cfg_we) rank_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[3:0], in_ch.valid};
  end

  function automatic logic [W-1:0] units(input logic [15:0] h);
    logic [4:0] e;
    logic [W-1:0] m;
    e = h[14:10];
    m = W'(h[9:0]);
    if (e == 5'd0) return m;
    return (m | W'(11'h400)) << (e - 5'd1);
  endfunction

  function automatic logic [W-1:0] rnd(input logic [W-1:0] a, input logic [5:0] p,
                                       input logic [5:0] sig);
    logic [5:0] s;
    logic [W-1:0] q, rem, half, one;
    one = W'(1);
    if (p < sig) return a;
    s = p - (sig - 6'd1);
    q = a >> s;
    rem = a & ((one << s) - one);
    half = one << (s - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + one;
    return q << s;
  endfunction

  function automatic logic [5:0] top(input logic [W-1:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < W; i++) if (v[i]) p = 6'(i);
    return p;
  endfunction

  // stage 1: order, classify, convert to fixed point
  logic [15:0] x, y;
  logic        sp1_r, sv1_r, xs1_r, ys1_r, last1_r;
  logic [15:0] spec1_r;
  logic [W-1:0] xm1_r, ym1_r;
  logic        xn, yn, xi, yi;
  logic [15:0] spec;
  logic        sp;

  always_comb begin
    x = rank_r ? in_ch.payload.peer_value : in_ch.payload.local_value;
    y = rank_r ? in_ch.payload.local_value : in_ch.payload.peer_value;
    xn = (x[14:10] == 5'h1F) && (x[9:0] != 10'd0);
    yn = (y[14:10] == 5'h1F) && (y[9:0] != 10'd0);
    xi = x[14:0] == hpoa_pkg::HExpMask[14:0];
    yi = y[14:0] == hpoa_pkg::HExpMask[14:0];
    sp = 1'b1;
    spec = x;
    if (xn) spec = x | hpoa_pkg::HQuiet;
    else if (yn) spec = y | hpoa_pkg::HQuiet;
    else if (xi && yi) spec = (x[15] ^ y[15]) ? hpoa_pkg::HDefaultNan : x;
    else if (xi) spec = x;
    else if (yi) spec = y;
    else sp = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp1_r <= sp;
      spec1_r <= spec;
      xs1_r <= x[15];
      ys1_r <= y[15];
      xm1_r <= units(x);
      ym1_r <= units(y);
      last1_r <= in_ch.payload.last_in;
      sv1_r <= x[15] & y[15];
    end
  end

  // stage 2: signed magnitude add
  logic sp2_r, neg2_r, bz2_r, last2_r;
  logic [15:0] spec2_r;
  logic [W-1:0] mag2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sp2_r <= sp1_r;
      spec2_r <= spec1_r;
      last2_r <= last1_r;
      bz2_r <= sv1_r;
      if (xs1_r == ys1_r) begin
        mag2_r <= xm1_r + ym1_r;
        neg2_r <= xs1_r;
      end else if (xm1_r >= ym1_r) begin
        mag2_r <= xm1_r - ym1_r;
        neg2_r <= xs1_r;
      end else begin
        mag2_r <= ym1_r - xm1_r;
        neg2_r <= ys1_r;
      end
    end
  end

  // stage 3: round to 24 significant bits
  logic sp3_r, neg3_r, bz3_r, last3_r;
  logic [15:0] spec3_r;
  logic [W-1:0] mag3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sp3_r <= sp2_r;
      spec3_r <= spec2_r;
      neg3_r <= neg2_r;
      bz3_r <= bz2_r;
      last3_r <= last2_r;
      mag3_r <= rnd(mag2_r, top(mag2_r), 6'd24);
    end
  end

  // stage 4: round to 11 significant bits
  logic sp4_r, neg4_r, bz4_r, last4_r;
  logic [15:0] spec4_r;
  logic [W-1:0] mag4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sp4_r <= sp3_r;
      spec4_r <= spec3_r;
      neg4_r <= neg3_r;
      bz4_r <= bz3_r;
      last4_r <= last3_r;
      mag4_r <= rnd(mag3_r, top(mag3_r), 6'd11);
    end
  end

  // stage 5: encode into the output register
  logic [15:0] res;
  logic [5:0]  p4;
  logic [W-1:0] sh;
  logic [15:0] sum5_r;
  logic        last5_r;
  always_comb begin
    p4 = top(mag4_r);
    sh = mag4_r >> (p4 - 6'd10);
    if (sp4_r) res = spec4_r;
    else if (mag4_r == '0) res = bz4_r ? hpoa_pkg::HSign : 16'h0000;
    else if (mag4_r < W'(11'h400)) res = {neg4_r, 5'd0, mag4_r[9:0]};
    else if (p4 >= 6'd40) res = {neg4_r, 15'h7C00};
    else res = {neg4_r, 5'(p4 - 6'd9), sh[9:0]};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sum5_r <= res;
      last5_r <= last4_r;
    end
  end

  assign out_ch.valid = v_r[4];
  assign out_ch.payload.sum_value = sum5_r;
  assign out_ch.payload.last_out = last5_r;

  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "beat dropped")
  `ASSERT_IMPLIES(a_stall, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready, "accept in stall")
  `ASSERT_NEXT(a_flow, clk, rst_n, in_ch.valid && in_ch.ready, v_r[0], "beat lost at entry")
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  localparam int TimeoutCycles = 400000;
  localparam int TailCycles = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  hpoa_in_if in_ch ();
  hpoa_out_if out_ch ();

  half_precision_ordered_add u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hpoa_pkg::in_beat_t pending_beats[$];
  hpoa_pkg::out_beat_t expected_sums[$];
  logic rank_sel = 1'b0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic logic [63:0] half_mag(logic [15:0] h);
    logic [4:0] e;
    logic [63:0] m;
    e = h[14:10];
    m = {54'd0, h[9:0]};
    if (e == 5'd0) return m;
    return (m | 64'h400) << (e - 1);
  endfunction

  function automatic int msb_pos(logic [63:0] v);
    int p;
    p = -1;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  function automatic logic [63:0] round_to_bits(logic [63:0] a, int nbits);
    int p;
    int s;
    logic [63:0] q, rem, half;
    p = msb_pos(a);
    if (p < nbits) return a;
    s = p - (nbits - 1);
    q = a >> s;
    rem = a & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q << s;
  endfunction

  function automatic logic [15:0] pack_half(logic [63:0] mag);
    int p;
    if (mag < 64'h400) return mag[15:0];
    p = msb_pos(mag);
    if (p >= 40) return hpoa_pkg::HExpMask;
    return {1'b0, 5'(p - 9), 10'(mag >> (p - 10))};
  endfunction

  function automatic logic [15:0] ordered_sum(logic [15:0] x, logic [15:0] y);
    logic xnan, ynan, xinf, yinf;
    longint sx, sy, total;
    logic [63:0] mag;
    xnan = (x[14:10] == 5'h1f) && (x[9:0] != 0);
    ynan = (y[14:10] == 5'h1f) && (y[9:0] != 0);
    xinf = (x[14:0] == hpoa_pkg::HExpMask[14:0]);
    yinf = (y[14:0] == hpoa_pkg::HExpMask[14:0]);
    if (xnan) return x | hpoa_pkg::HQuiet;
    if (ynan) return y | hpoa_pkg::HQuiet;
    if (xinf && yinf) return (x[15] ^ y[15]) ? hpoa_pkg::HDefaultNan : x;
    if (xinf) return x;
    if (yinf) return y;
    sx = longint'(half_mag(x));
    sy = longint'(half_mag(y));
    if (x[15]) sx = -sx;
    if (y[15]) sy = -sy;
    total = sx + sy;
    if (total == 0) return (x[15] & y[15]) ? hpoa_pkg::HSign : 16'h0000;
    mag = (total < 0) ? 64'(-total) : 64'(total);
    mag = round_to_bits(round_to_bits(mag, 24), 11);
    return {(total < 0), 15'd0} | pack_half(mag);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_beats.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on each accepted beat
  always @(posedge clk) begin
    hpoa_pkg::out_beat_t exp_beat;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      exp_beat.sum_value = rank_sel
        ? ordered_sum(in_ch.payload.peer_value, in_ch.payload.local_value)
        : ordered_sum(in_ch.payload.local_value, in_ch.payload.peer_value);
      exp_beat.last_out = in_ch.payload.last_in;
      expected_sums.push_back(exp_beat);
    end
  end

  // monitor
  always @(posedge clk) begin
    hpoa_pkg::out_beat_t exp_beat;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", out_ch.payload);
        end else begin
          exp_beat = expected_sums.pop_front();
          if (out_ch.payload.sum_value !== exp_beat.sum_value ||
              out_ch.payload.last_out !== exp_beat.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sum exp %h got %h, last exp %b got %b",
                       exp_beat.sum_value, out_ch.payload.sum_value,
                       exp_beat.last_out, out_ch.payload.last_out);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(9))
      0: h[14:10] = 5'h1f;
      1: h[14:10] = 5'h00;
      2: h[14:10] = 5'h1e;
      default: ;
    endcase
    return h;
  endfunction

  task automatic queue_beat(logic [15:0] a, logic [15:0] b, logic last);
    hpoa_pkg::in_beat_t beat;
    beat.local_value = a;
    beat.peer_value = b;
    beat.last_in = last;
    pending_beats.push_back(beat);
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_ch.valid || expected_sums.size() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic set_rank(logic r);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    rank_sel = r;
  endtask

  task automatic queue_random(int count);
    logic [15:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_half();
      b = rand_half();
      // push toward cancellation and near-ties
      if ($urandom_range(4) == 0) b = {~a[15], a[14:0]} ^ 16'($urandom_range(3));
      queue_beat(a, b, ($urandom_range(7) == 0));
    end
  endtask

  task automatic queue_directed();
    queue_beat(16'h0000, 16'h0000, 1'b0);
    queue_beat(16'h8000, 16'h8000, 1'b1);
    queue_beat(16'h8000, 16'h0000, 1'b0);
    queue_beat(16'h7bff, 16'h7bff, 1'b0);
    queue_beat(16'hfbff, 16'hfbff, 1'b1);
    queue_beat(16'h7c00, 16'hfc00, 1'b0);
    queue_beat(16'h7c00, 16'h7c00, 1'b0);
    queue_beat(16'hfc00, 16'h3c00, 1'b0);
    queue_beat(16'h3c00, 16'h7c00, 1'b0);
    queue_beat(16'h7d01, 16'hfe55, 1'b1);
    queue_beat(16'h3c00, 16'hfd23, 1'b0);
    queue_beat(16'hffff, 16'h7c01, 1'b0);
    queue_beat(16'h0001, 16'h8001, 1'b0);
    queue_beat(16'h0001, 16'h0001, 1'b0);
    queue_beat(16'h03ff, 16'h0001, 1'b1);
    queue_beat(16'h3c00, 16'h1000, 1'b0);
    queue_beat(16'h3c00, 16'h0001, 1'b0);
    queue_beat(16'h7bff, 16'h4000, 1'b0);
    queue_beat(16'h5555, 16'haaaa, 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    set_rank(1'b1);
    queue_directed();
    set_rank(1'b0);
    queue_random(300);
    drain();
    src_idle_pct = 75;
    queue_random(250);
    set_rank(1'b1);
    src_idle_pct = 0;
    sink_stall_pct = 75;
    queue_random(250);
    // hold off until every result is back
    drain();
    queue_random(100);
    set_rank(1'b0);
    src_idle_pct = 32;
    sink_stall_pct = 32;
    queue_random(200);
    set_rank(1'b1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    queue_random(200);
    drain();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== half_precision_ordered_add.f =====
+incdir+rtl
rtl/hpoa_pkg.sv
rtl/hpoa_in_if.sv
rtl/hpoa_out_if.sv
rtl/half_precision_ordered_add.sv
tb/testbench.sv
